/* rtl/rhp_pkg.sv */
package rhp_pkg;

    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [15:0] DEF_MAX_LEN     = 16'd2000;
    localparam logic [15:0] DEF_EXT_PROFILE = 16'h4857;
    localparam logic [15:0] MIN_PKT_LEN     = 16'd12;
    localparam logic [15:0] MAX_COUNT       = 16'hFFFF;
    localparam logic [6:0]  FIXED_LEN       = 7'd12;
    localparam logic [1:0]  RTP_VERSION     = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LEN        = 2'd0,
        CFG_EXT_PROFILE    = 2'd1,
        CFG_EXT_SIZE_FILL  = 2'd2,
        CFG_EXT_SIZE_MULTI = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_SHORT          = 3'd1,
        ST_LONG           = 3'd2,
        ST_SHORT_CSRC     = 3'd3,
        ST_BAD_VERSION    = 3'd4,
        ST_SHORT_EXT_HDR  = 3'd5,
        ST_SHORT_EXT_DATA = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        EXT_NONE    = 2'd0,
        EXT_PROFILE = 2'd1,
        EXT_FILL    = 2'd2,
        EXT_MULTI   = 2'd3
    } t_ext_kind;

    typedef struct packed {
        logic [15:0] max_packet_len;
        logic [15:0] ext_profile_id;
        logic [15:0] ext_size_fill;
        logic [15:0] ext_size_multi;
    } t_cfg;

    // everything the verdict needs, captured over one packet
    typedef struct packed {
        logic [15:0] len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [6:0]  fhl;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [31:0] ssrc;
        logic [15:0] ext_prof;
        logic [15:0] ext_words;
        logic [7:0]  pad;
    } t_pkt_sum;

    typedef struct packed {
        t_status     status;
        logic [15:0] head_len;
        logic [15:0] packet_len;
        logic [6:0]  fixed_head_len;
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic [6:0]  payload_type;
        logic        marker_bit;
        logic [31:0] sync_source;
        t_ext_kind   ext_kind;
        logic        padding_bad;
    } t_hdr_res;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic [Q_AW:0]   count;
    } t_q_stat;

endpackage

/* rtl/rhp_in_if.sv */
interface rhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/rhp_out_if.sv */
interface rhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] head_len;
    logic [15:0] packet_len;
    logic [6:0]  fixed_head_len;
    logic [15:0] seq_number;
    logic [31:0] time_stamp;
    logic [6:0]  payload_type;
    logic        marker_bit;
    logic [31:0] sync_source;
    logic [1:0]  ext_kind;
    logic        padding_bad;

    modport source(
        output valid, output status, output head_len, output packet_len,
        output fixed_head_len, output seq_number, output time_stamp,
        output payload_type, output marker_bit, output sync_source,
        output ext_kind, output padding_bad, input ready
    );
    modport sink(
        input valid, input status, input head_len, input packet_len,
        input fixed_head_len, input seq_number, input time_stamp,
        input payload_type, input marker_bit, input sync_source,
        input ext_kind, input padding_bad, output ready
    );
endinterface

/* rtl/rhp_front.sv */
module rhp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rhp_in_if.sink            i_pkt,
    input  logic              i_q_full,
    output logic              o_push,
    output rhp_pkg::t_pkt_sum o_sum
);
    import rhp_pkg::*;

    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_first, n_first;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_stamp, n_stamp;
    logic [31:0] r_ssrc, n_ssrc;
    logic [15:0] r_ext_prof, n_ext_prof;
    logic [15:0] r_ext_words, n_ext_words;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] pos;
    logic [3:0]  cc;
    logic [6:0]  fhl;
    logic [15:0] fhl16;

    assign i_pkt.ready = !i_q_full;
    assign accept      = i_pkt.valid && !i_q_full;
    assign b           = i_pkt.data_byte;
    assign pos         = r_byte_count;

    always_comb begin
        // csrc count comes from the byte in flight when it is byte 0
        cc    = (pos == 16'd0) ? b[3:0] : r_first[11:8];
        fhl   = FIXED_LEN + {1'b0, cc, 2'b00};
        fhl16 = {9'd0, fhl};

        n_first     = r_first;
        n_seq       = r_seq;
        n_stamp     = r_stamp;
        n_ssrc      = r_ssrc;
        n_ext_prof  = r_ext_prof;
        n_ext_words = r_ext_words;

        priority if (pos == 16'd0) begin
            n_first = {b, r_first[7:0]};
        end else if (pos == 16'd1) begin
            n_first = {r_first[15:8], b};
        end else if (pos < 16'd4) begin
            n_seq = {r_seq[7:0], b};
        end else if (pos < 16'd8) begin
            n_stamp = {r_stamp[23:0], b};
        end else if (pos < 16'd12) begin
            n_ssrc = {r_ssrc[23:0], b};
        end else begin
        end

        priority if (pos >= fhl16 && pos < fhl16 + 16'd2) begin
            n_ext_prof = {r_ext_prof[7:0], b};
        end else if (pos >= fhl16 + 16'd2 && pos < fhl16 + 16'd4) begin
            n_ext_words = {r_ext_words[7:0], b};
        end else begin
        end

        n_byte_count = (pos != MAX_COUNT) ? pos + 16'd1 : pos;
    end

    assign o_push = accept && i_pkt.last_byte;

    always_comb begin
        o_sum.len       = n_byte_count;
        o_sum.b0        = n_first[15:8];
        o_sum.b1        = n_first[7:0];
        o_sum.fhl       = fhl;
        o_sum.seq       = n_seq;
        o_sum.stamp     = n_stamp;
        o_sum.ssrc      = n_ssrc;
        o_sum.ext_prof  = n_ext_prof;
        o_sum.ext_words = n_ext_words;
        o_sum.pad       = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_count <= '0;
            r_first      <= '0;
            r_seq        <= '0;
            r_stamp      <= '0;
            r_ssrc       <= '0;
            r_ext_prof   <= '0;
            r_ext_words  <= '0;
        end else if (accept) begin
            r_byte_count <= n_byte_count;
            r_first      <= n_first;
            r_seq        <= n_seq;
            r_stamp      <= n_stamp;
            r_ssrc       <= n_ssrc;
            r_ext_prof   <= n_ext_prof;
            r_ext_words  <= n_ext_words;
        end
    end

endmodule

/* rtl/rhp_queue.sv */
module rhp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rhp_pkg::t_pkt_sum i_data,
    input  logic              i_pop,
    output rhp_pkg::t_pkt_sum o_data,
    output rhp_pkg::t_q_stat  o_stat
);
    import rhp_pkg::*;

    t_pkt_sum          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_data       = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/rhp_back.sv */
module rhp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rhp_pkg::t_cfg     i_cfg,
    input  rhp_pkg::t_pkt_sum i_sum,
    input  logic              i_q_empty,
    output logic              o_pop,
    rhp_out_if.source         o_hdr
);
    import rhp_pkg::*;

    logic      r_valid;
    t_hdr_res  r_res;
    t_hdr_res  res;

    logic [18:0] len19;
    logic [18:0] head19;
    logic [17:0] body;
    logic [15:0] ext_hdr_end;
    logic [15:0] plen;
    logic        padbad;
    t_ext_kind   kind;
    t_status     status;

    assign o_pop = !i_q_empty && (!r_valid || o_hdr.ready);

    always_comb begin
        len19       = {3'd0, i_sum.len};
        body        = {i_sum.ext_words, 2'b00};
        head19      = {12'd0, i_sum.fhl} + 19'd4 + {1'b0, body};
        ext_hdr_end = {9'd0, i_sum.fhl} + 16'd4;

        // padding count is honored only when it leaves something behind
        plen   = i_sum.len;
        padbad = 1'b0;
        if (i_sum.b0[5]) begin
            if (i_sum.len > {8'd0, i_sum.pad}) begin
                plen = i_sum.len - {8'd0, i_sum.pad};
            end else begin
                padbad = 1'b1;
            end
        end

        kind = EXT_NONE;
        if (i_sum.ext_prof == i_cfg.ext_profile_id) begin
            priority if (body == {2'b00, i_cfg.ext_size_fill}) begin
                kind = EXT_FILL;
            end else if (body == {2'b00, i_cfg.ext_size_multi}) begin
                kind = EXT_MULTI;
            end else begin
                kind = EXT_PROFILE;
            end
        end

        priority if (i_sum.len < MIN_PKT_LEN) begin
            status = ST_SHORT;
        end else if (i_sum.len > i_cfg.max_packet_len) begin
            status = ST_LONG;
        end else if (i_sum.len < {9'd0, i_sum.fhl}) begin
            status = ST_SHORT_CSRC;
        end else if (i_sum.b0[7:6] != RTP_VERSION) begin
            status = ST_BAD_VERSION;
        end else if (i_sum.b0[4] && i_sum.len < ext_hdr_end) begin
            status = ST_SHORT_EXT_HDR;
        end else if (i_sum.b0[4] && len19 < head19) begin
            status = ST_SHORT_EXT_DATA;
        end else begin
            status = ST_OK;
        end

        res = '0;
        res.status = status;
        if (status == ST_OK) begin
            res.head_len       = i_sum.b0[4] ? head19[15:0] : {9'd0, i_sum.fhl};
            res.packet_len     = plen;
            res.fixed_head_len = i_sum.fhl;
            res.seq_number     = i_sum.seq;
            res.time_stamp     = i_sum.stamp;
            res.payload_type   = i_sum.b1[6:0];
            res.marker_bit     = i_sum.b1[7];
            res.sync_source    = i_sum.ssrc;
            res.ext_kind       = i_sum.b0[4] ? kind : EXT_NONE;
            res.padding_bad    = padbad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_hdr.ready) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= res;
        end
    end

    assign o_hdr.valid          = r_valid;
    assign o_hdr.status         = r_res.status;
    assign o_hdr.head_len       = r_res.head_len;
    assign o_hdr.packet_len     = r_res.packet_len;
    assign o_hdr.fixed_head_len = r_res.fixed_head_len;
    assign o_hdr.seq_number     = r_res.seq_number;
    assign o_hdr.time_stamp     = r_res.time_stamp;
    assign o_hdr.payload_type   = r_res.payload_type;
    assign o_hdr.marker_bit     = r_res.marker_bit;
    assign o_hdr.sync_source    = r_res.sync_source;
    assign o_hdr.ext_kind       = r_res.ext_kind;
    assign o_hdr.padding_bad    = r_res.padding_bad;

endmodule

/* rtl/rtp_header_parser.sv */
// rtp header parser
// i_pkt carries one rtp packet, one byte per beat in wire order, with
// last_byte high on the final beat. o_hdr carries one verdict per packet:
// status plus the decoded header fields, all fields zero on a failure.
// i_cfg_we/i_cfg_idx/i_cfg_data write the four settings registers
// (max length, extension profile id, fill and multi body sizes); write them
// only while no packet is in flight.
// throughput: one byte per cycle while the summary queue is not full, back to
// back; packets may follow each other with no gap. the front capture logic
// handles one byte per cycle whenever i_pkt.ready is high. the summary enters
// the queue at the edge that takes the last byte, and the verdict stage loads
// its output register, raising o_hdr.valid, once that register is free or taken.
// a four-entry queue of packet summaries sits between capture and verdict,
// so capture keeps taking bytes while o_hdr is stalled; i_pkt.ready drops
// only once five verdicts are backed up (one held on o_hdr, four queued).
// reset: synchronous, active low; clears the capture state, the queue and
// the output valid, and loads the register defaults (2000, 0x4857, 0, 0)
module rtp_header_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rhp_in_if.sink                            i_pkt,
    rhp_out_if.source                         o_hdr,
    input  logic                              i_cfg_we,
    input  logic [rhp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rhp_pkg::CFG_W-1:0]         i_cfg_data
);
    import rhp_pkg::*;

    t_cfg      r_cfg;
    t_pkt_sum  push_sum;
    t_pkt_sum  head_sum;
    t_q_stat   q_stat;
    logic      push;
    logic      pop;

    // settings registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_packet_len <= DEF_MAX_LEN;
            r_cfg.ext_profile_id <= DEF_EXT_PROFILE;
            r_cfg.ext_size_fill  <= '0;
            r_cfg.ext_size_multi <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_LEN:        r_cfg.max_packet_len <= i_cfg_data;
                CFG_EXT_PROFILE:    r_cfg.ext_profile_id <= i_cfg_data;
                CFG_EXT_SIZE_FILL:  r_cfg.ext_size_fill  <= i_cfg_data;
                CFG_EXT_SIZE_MULTI: r_cfg.ext_size_multi <= i_cfg_data;
            endcase
        end
    end

    // byte capture, pushes one summary on the last beat
    rhp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pkt    (i_pkt),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_sum    (push_sum)
    );

    // summary queue decouples capture from the verdict stage
    rhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_sum),
        .i_pop   (pop),
        .o_data  (head_sum),
        .o_stat  (q_stat)
    );

    // checks and output register
    rhp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_sum     (head_sum),
        .i_q_empty (q_stat.empty),
        .o_pop     (pop),
        .o_hdr     (o_hdr)
    );

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= (Q_AW + 1)'(Q_DEPTH))
        else $error("summary queue count out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hdr.valid && o_hdr.status != ST_OK) |->
        (o_hdr.head_len == 16'd0 && o_hdr.packet_len == 16'd0 &&
         o_hdr.fixed_head_len == 7'd0 && o_hdr.ext_kind == EXT_NONE))
        else $error("failed verdict carries nonzero fields");

    a_ok_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hdr.valid && o_hdr.status == ST_OK) |->
        ({9'd0, o_hdr.fixed_head_len} <= o_hdr.head_len &&
         o_hdr.fixed_head_len >= FIXED_LEN))
        else $error("header length below fixed header length");

    a_pop_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_stat.empty && !o_hdr.valid) |=> o_hdr.valid)
        else $error("pending verdict not presented");
`endif

endmodule

/* sim/tb_rtp_header_parser.sv */
`timescale 1ns / 100ps

// checks rtp_header_parser against a cycle-free header decoder written here.
// bytes go in through i_pkt in bursts with random gaps, verdicts are taken
// from o_hdr under a changing stall pattern, and every verdict is compared
// field by field with the oldest predicted one.
module tb_rtp_header_parser;
    import rhp_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    rhp_in_if  pkt_if ();
    rhp_out_if hdr_if ();

    rtp_header_parser u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (pkt_if),
        .o_hdr      (hdr_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // decoder copy of the settings and of the per-packet capture
    t_cfg        cfg_copy;
    logic [15:0] cap_count;
    logic [15:0] cap_first;
    logic [15:0] cap_seq;
    logic [31:0] cap_stamp;
    logic [31:0] cap_ssrc;
    logic [15:0] cap_prof;
    logic [15:0] cap_words;

    t_hdr_res    verdict_q[$];
    logic [7:0]  pkt_q[$];
    int          mismatch_cnt;
    int          burst_left;
    int          bytes_sent;

    wire in_beat  = pkt_if.valid && pkt_if.ready;
    wire out_beat = hdr_if.valid && hdr_if.ready;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // decode one byte; returns 1 with the verdict on the final byte
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_hdr_res res);
        int unsigned pos, fhl, len, head, plen, body;
        logic [7:0]  b0;
        t_status     st;
        t_ext_kind   kind;
        logic        padbad;
        res = '0;
        pos = cap_count;
        fhl = FIXED_LEN + 4 * cap_first[11:8];
        if (pos == 0) begin
            cap_first[15:8] = b;
            fhl = FIXED_LEN + 4 * b[3:0];
        end else if (pos == 1) begin
            cap_first[7:0] = b;
        end else if (pos < 4) begin
            cap_seq = {cap_seq[7:0], b};
        end else if (pos < 8) begin
            cap_stamp = {cap_stamp[23:0], b};
        end else if (pos < 12) begin
            cap_ssrc = {cap_ssrc[23:0], b};
        end
        if (pos >= fhl && pos < fhl + 2)
            cap_prof = {cap_prof[7:0], b};
        else if (pos >= fhl + 2 && pos < fhl + 4)
            cap_words = {cap_words[7:0], b};
        if (cap_count != MAX_COUNT)
            cap_count++;
        if (!last)
            return 1'b0;

        len    = cap_count;
        b0     = cap_first[15:8];
        head   = fhl;
        plen   = len;
        kind   = EXT_NONE;
        padbad = 1'b0;
        st     = ST_OK;
        if (len < MIN_PKT_LEN) begin
            st = ST_SHORT;
        end else if (len > cfg_copy.max_packet_len) begin
            st = ST_LONG;
        end else if (len < fhl) begin
            st = ST_SHORT_CSRC;
        end else if (b0[7:6] != RTP_VERSION) begin
            st = ST_BAD_VERSION;
        end else begin
            // padding count is the last byte, unsigned
            if (b0[5]) begin
                if (plen > b) plen -= b;
                else padbad = 1'b1;
            end
            if (b0[4]) begin
                if (len < fhl + 4) begin
                    st = ST_SHORT_EXT_HDR;
                end else begin
                    body = cap_words * 4;
                    head = fhl + 4 + body;
                    if (len < head) begin
                        st = ST_SHORT_EXT_DATA;
                    end else if (cap_prof == cfg_copy.ext_profile_id) begin
                        // fill size wins when both sizes match
                        kind = EXT_PROFILE;
                        if (body == cfg_copy.ext_size_fill) kind = EXT_FILL;
                        else if (body == cfg_copy.ext_size_multi) kind = EXT_MULTI;
                    end
                end
            end
        end

        res.status = st;
        if (st == ST_OK) begin
            res.head_len       = head[15:0];
            res.packet_len     = plen[15:0];
            res.fixed_head_len = fhl[6:0];
            res.seq_number     = cap_seq;
            res.time_stamp     = cap_stamp;
            res.payload_type   = cap_first[6:0];
            res.marker_bit     = cap_first[7];
            res.sync_source    = cap_ssrc;
            res.ext_kind       = kind;
            res.padding_bad    = padbad;
        end
        cap_count = '0;
        cap_first = '0;
        cap_seq   = '0;
        cap_stamp = '0;
        cap_ssrc  = '0;
        cap_prof  = '0;
        cap_words = '0;
        return 1'b1;
    endfunction

    // one byte beat, with the burst/gap pacing of the sender
    task automatic send_byte(input logic [7:0] value, input logic last);
        t_hdr_res want;
        int       gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(1, 8);
                default: gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(0, 2);
            endcase
            if (gap > 0) begin
                pkt_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        pkt_if.valid     <= 1'b1;
        pkt_if.data_byte <= value;
        pkt_if.last_byte <= last;
        do @(posedge i_clk); while (!pkt_if.ready);
        if (parse_byte(value, last, want))
            verdict_q.push_back(want);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_packet();
        foreach (pkt_q[i])
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
        pkt_q.delete();
    endtask

    // sender holds off until every verdict is out, plus the pipeline depth
    task automatic wait_drained();
        pkt_if.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (verdict_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic apply_cfg(input logic [15:0] max_len, input logic [15:0] prof,
                             input logic [15:0] fill, input logic [15:0] multi);
        wait_drained();
        write_reg(CFG_MAX_LEN, max_len);
        write_reg(CFG_EXT_PROFILE, prof);
        write_reg(CFG_EXT_SIZE_FILL, fill);
        write_reg(CFG_EXT_SIZE_MULTI, multi);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        cfg_copy = '{max_len, prof, fill, multi};
    endtask

    task automatic push16(input logic [15:0] v);
        pkt_q.push_back(v[15:8]);
        pkt_q.push_back(v[7:0]);
    endtask

    task automatic push_random(input int n);
        repeat (n) pkt_q.push_back(8'($urandom));
    endtask

    // fixed header followed by the csrc list that byte 0 declares
    task automatic push_header(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [15:0] seq, input logic [31:0] ts,
                               input logic [31:0] ssrc);
        pkt_q.push_back(b0);
        pkt_q.push_back(b1);
        push16(seq);
        push16(ts[31:16]);
        push16(ts[15:0]);
        push16(ssrc[31:16]);
        push16(ssrc[15:0]);
        push_random(4 * b0[3:0]);
    endtask

    task automatic push_padding(input int n);
        push_random(n - 1);
        pkt_q.push_back(8'(n));
    endtask

    task automatic test_reset_defaults();
        push_header({2'd2, 1'b0, 1'b0, 4'd0}, 8'h00, 16'h0000, 32'h0, 32'h0);
        send_packet();
        // zero-word extension with the default profile: both sizes match
        push_header({2'd2, 1'b0, 1'b1, 4'd1}, 8'h65, 16'h1234, 32'h89ABCDEF, 32'h01020304);
        push16(DEF_EXT_PROFILE);
        push16(16'h0000);
        push_random(5);
        send_packet();
    endtask

    task automatic test_short_packets();
        pkt_q.push_back(8'h80);
        send_packet();
        push_random(11);
        send_packet();
    endtask

    task automatic test_bad_version();
        push_header({2'd0, 1'b0, 1'b0, 4'd0}, 8'h11, 16'h1, 32'h2, 32'h3);
        send_packet();
        push_header({2'd1, 1'b1, 1'b1, 4'd0}, 8'h22, 16'h4, 32'h5, 32'h6);
        send_packet();
        push_header({2'd3, 1'b0, 1'b0, 4'd0}, 8'h33, 16'h7, 32'h8, 32'h9);
        send_packet();
    endtask

    task automatic test_source_list();
        // full list with all-ones header fields
        push_header({2'd2, 1'b0, 1'b0, 4'd15}, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_packet();
        push_header({2'd2, 1'b0, 1'b0, 4'd15}, 8'h7F, 16'h5555, 32'hAAAAAAAA, 32'h55555555);
        void'(pkt_q.pop_back());
        send_packet();
        // list fits but no room for the extension header
        push_header({2'd2, 1'b0, 1'b1, 4'd15}, 8'h80, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA);
        send_packet();
    endtask

    task automatic test_padding();
        push_header({2'd2, 1'b1, 1'b0, 4'd0}, 8'h60, 16'h0100, 32'h1, 32'h2);
        push_random(5);
        push_padding(3);
        send_packet();
        push_header({2'd2, 1'b1, 1'b0, 4'd0}, 8'h61, 16'h0101, 32'h3, 32'h4);
        push_random(7);
        pkt_q.push_back(8'd0);
        send_packet();
        // count equal to the length, then one below it
        push_header({2'd2, 1'b1, 1'b0, 4'd0}, 8'h62, 16'h0102, 32'h5, 32'h6);
        push_random(7);
        pkt_q.push_back(8'd20);
        send_packet();
        push_header({2'd2, 1'b1, 1'b0, 4'd0}, 8'h63, 16'h0103, 32'h7, 32'h8);
        push_random(7);
        pkt_q.push_back(8'd19);
        send_packet();
        push_header({2'd2, 1'b1, 1'b0, 4'd0}, 8'h64, 16'h0104, 32'h9, 32'hA);
        push_random(7);
        pkt_q.push_back(8'hFF);
        send_packet();
    endtask

    task automatic test_extension();
        apply_cfg(DEF_MAX_LEN, 16'hA5C3, 16'd8, 16'd12);
        // extension header cut after three bytes
        push_header({2'd2, 1'b0, 1'b1, 4'd0}, 8'h10, 16'h0200, 32'h1, 32'h1);
        push16(16'hA5C3);
        pkt_q.push_back(8'h00);
        send_packet();
        // body one byte short
        push_header({2'd2, 1'b0, 1'b1, 4'd0}, 8'h11, 16'h0201, 32'h2, 32'h2);
        push16(16'hA5C3);
        push16(16'd2);
        push_random(7);
        send_packet();
        push_header({2'd2, 1'b0, 1'b1, 4'd2}, 8'h92, 16'h0202, 32'h3, 32'h3);
        push16(16'hA5C3);
        push16(16'd2);
        push_random(12);
        send_packet();
        push_header({2'd2, 1'b0, 1'b1, 4'd0}, 8'h13, 16'h0203, 32'h4, 32'h4);
        push16(16'hA5C3);
        push16(16'd3);
        push_random(12);
        send_packet();
        push_header({2'd2, 1'b1, 1'b1, 4'd0}, 8'h14, 16'h0204, 32'h5, 32'h5);
        push16(16'hA5C3);
        push16(16'd1);
        push_random(4);
        push_padding(2);
        send_packet();
        push_header({2'd2, 1'b0, 1'b1, 4'd0}, 8'h15, 16'h0205, 32'h6, 32'h6);
        push16(16'h5AC3);
        push16(16'd2);
        push_random(8);
        send_packet();
        push_header({2'd2, 1'b0, 1'b1, 4'd0}, 8'h16, 16'h0206, 32'h7, 32'h7);
        push16(16'hA5C3);
        push16(16'hFFFF);
        push_random(8);
        send_packet();
        apply_cfg(DEF_MAX_LEN, 16'h0000, 16'd8, 16'd8);
        push_header({2'd2, 1'b0, 1'b1, 4'd0}, 8'h17, 16'h0207, 32'h8, 32'h8);
        push16(16'h0000);
        push16(16'd2);
        push_random(8);
        send_packet();
    endtask

    task automatic test_max_length();
        apply_cfg(MIN_PKT_LEN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_header({2'd2, 1'b0, 1'b0, 4'd0}, 8'h20, 16'h0300, 32'h1, 32'h1);
        send_packet();
        push_header({2'd2, 1'b0, 1'b0, 4'd0}, 8'h21, 16'h0301, 32'h2, 32'h2);
        push_random(1);
        send_packet();
        // length right at the limit, padding count past the length
        apply_cfg(16'd40, DEF_EXT_PROFILE, 16'd0, 16'd0);
        push_header({2'd2, 1'b1, 1'b0, 4'd0}, 8'hA2, 16'h0302, 32'h3, 32'h3);
        push_random(40 - 13);
        pkt_q.push_back(8'd200);
        send_packet();
    endtask

    task automatic send_random_packet();
        int          sel, cc, words, cut;
        logic [1:0]  ver;
        logic        use_pad, use_ext;
        logic [15:0] prof;
        sel     = $urandom_range(0, 9);
        cc      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        use_pad = 1'($urandom_range(0, 1));
        use_ext = 1'($urandom_range(0, 1));
        ver     = (sel == 9) ? 2'($urandom_range(0, 3)) : RTP_VERSION;
        if (sel == 6) begin
            // plain noise
            push_random($urandom_range(1, 30));
        end else begin
            push_header({ver, use_pad, use_ext, 4'(cc)}, 8'($urandom), 16'($urandom),
                        $urandom, $urandom);
            if (use_ext) begin
                prof  = ($urandom_range(0, 2) != 0) ? cfg_copy.ext_profile_id
                                                    : 16'($urandom);
                words = $urandom_range(0, 3);
                push16(prof);
                push16(16'(words));
                push_random(4 * words);
            end
            push_random($urandom_range(0, 16));
            if (use_pad) begin
                if (sel == 7) pkt_q.push_back(8'($urandom));
                else push_padding($urandom_range(1, 8));
            end
            if (sel == 8) begin
                cut = $urandom_range(1, pkt_q.size());
                while (pkt_q.size() > cut) void'(pkt_q.pop_back());
            end
        end
        send_packet();
    endtask

    task automatic test_random_traffic();
        logic [15:0] max_len, prof;
        int          start;
        repeat (4) begin
            case ($urandom_range(0, 3))
                0: max_len = MAX_COUNT;
                1: max_len = DEF_MAX_LEN;
                2: max_len = 16'($urandom_range(12, 80));
                default: max_len = 16'($urandom_range(12, 65535));
            endcase
            case ($urandom_range(0, 2))
                0: prof = DEF_EXT_PROFILE;
                1: prof = 16'($urandom);
                default: prof = 16'h0000;
            endcase
            apply_cfg(max_len, prof, 16'(4 * $urandom_range(0, 4)),
                      16'(4 * $urandom_range(0, 4)));
            start = bytes_sent;
            while (bytes_sent - start < 60) begin
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
                send_random_packet();
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        pkt_if.valid     = 1'b0;
        pkt_if.data_byte = '0;
        pkt_if.last_byte = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_MAX_LEN;
        cfg_data         = '0;
        cfg_copy         = '{DEF_MAX_LEN, DEF_EXT_PROFILE, 16'd0, 16'd0};
        cap_count        = '0;
        cap_first        = '0;
        cap_seq          = '0;
        cap_stamp        = '0;
        cap_ssrc         = '0;
        cap_prof         = '0;
        cap_words        = '0;
        mismatch_cnt     = 0;
        burst_left       = 0;
        bytes_sent       = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_defaults();
        test_short_packets();
        test_bad_version();
        test_source_list();
        test_padding();
        test_extension();
        test_max_length();
        test_random_traffic();

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0 && verdict_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: stretches of always-ready, random and bursty stalls
    initial begin : rx_pattern
        int   mode, span, hold;
        logic level;
        hdr_if.ready = 1'b0;
        hold  = 0;
        level = 1'b1;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: hdr_if.ready <= 1'b1;
                    1: hdr_if.ready <= 1'($urandom_range(0, 1));
                    2: hdr_if.ready <= ($urandom_range(0, 7) != 0);
                    default: begin
                        if (hold == 0) begin
                            level = ~level;
                            hold  = level ? $urandom_range(1, 6) : $urandom_range(1, 12);
                        end
                        hold--;
                        hdr_if.ready <= level;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_verdict
        t_hdr_res got, want;
        string    bad;
        if (i_rst_n && out_beat) begin
            got.status         = t_status'(hdr_if.status);
            got.head_len       = hdr_if.head_len;
            got.packet_len     = hdr_if.packet_len;
            got.fixed_head_len = hdr_if.fixed_head_len;
            got.seq_number     = hdr_if.seq_number;
            got.time_stamp     = hdr_if.time_stamp;
            got.payload_type   = hdr_if.payload_type;
            got.marker_bit     = hdr_if.marker_bit;
            got.sync_source    = hdr_if.sync_source;
            got.ext_kind       = t_ext_kind'(hdr_if.ext_kind);
            got.padding_bad    = hdr_if.padding_bad;
            if (verdict_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected verdict beat: got %h", got);
            end else begin
                want = verdict_q.pop_front();
                bad  = "";
                if (got.status !== want.status) bad = {bad, " status"};
                if (got.head_len !== want.head_len) bad = {bad, " head_len"};
                if (got.packet_len !== want.packet_len) bad = {bad, " packet_len"};
                if (got.fixed_head_len !== want.fixed_head_len) bad = {bad, " fixed_head_len"};
                if (got.seq_number !== want.seq_number) bad = {bad, " seq_number"};
                if (got.time_stamp !== want.time_stamp) bad = {bad, " time_stamp"};
                if (got.payload_type !== want.payload_type) bad = {bad, " payload_type"};
                if (got.marker_bit !== want.marker_bit) bad = {bad, " marker_bit"};
                if (got.sync_source !== want.sync_source) bad = {bad, " sync_source"};
                if (got.ext_kind !== want.ext_kind) bad = {bad, " ext_kind"};
                if (got.padding_bad !== want.padding_bad) bad = {bad, " padding_bad"};
                if (bad != "") begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("verdict differs in%s: want %h got %h", bad, want, got);
                end
            end
        end
    end

    // no beat on either side for too long means the block is stuck
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (in_beat || out_beat) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/rhp_pkg.sv
rtl/rhp_in_if.sv
rtl/rhp_out_if.sv
rtl/rhp_front.sv
rtl/rhp_queue.sv
rtl/rhp_back.sv
rtl/rtp_header_parser.sv
sim/tb_rtp_header_parser.sv
